@@ rtl/gmlp_pkg.sv @@
// gmlp_pkg: shared constants, codes and item types for the gopher menu line parser
// no dependencies; used by every module of the block except gmlp_fifo

package gmlp_pkg;

  localparam int MAX_LINE_BYTES_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF    = 2;

  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 10;
  localparam int PORT_W   = 32;
  localparam int DIGIT_W  = 4;
  localparam int FIELD_W  = 3;
  localparam int ACC_W    = 36;

  localparam int TEXT_FIELDS = 3;
  localparam logic [FIELD_W-1:0] FIELD_PORT = 3'd3;
  localparam logic [FIELD_W-1:0] FIELD_SAT  = 3'd4;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] TYPE_INFO = 8'h69;

  localparam logic [PORT_W-1:0] PORT_NEG_LIMIT = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } port_phase_t;

  typedef struct packed {
    logic               command;
    logic [BYTE_W-1:0]  data_byte;
    logic               is_tab;
    logic               is_trim;
    logic               is_cspace;
    logic               is_digit;
    logic               is_sign;
    logic               is_minus;
    logic [DIGIT_W-1:0] digit;
  } cmd_item_t;

  typedef struct packed {
    logic      valid;
    cmd_item_t item;
  } front_out_t;

  typedef struct packed {
    logic [BYTE_W-1:0]        type_code;
    logic                     line_valid;
    logic signed [PORT_W-1:0] port_number;
    logic [OFFSET_W-1:0]      display_start;
    logic [OFFSET_W-1:0]      display_length;
    logic [OFFSET_W-1:0]      selector_start;
    logic [OFFSET_W-1:0]      selector_length;
    logic [OFFSET_W-1:0]      host_start;
    logic [OFFSET_W-1:0]      host_length;
    logic                     too_long;
  } result_t;

endpackage

@@ rtl/gopher_menu_line_parser.sv @@
// gopher_menu_line_parser: top level of the gopher directory line parser
// depends on gmlp_pkg, gmlp_front, gmlp_back and gmlp_fifo

// One byte item per cycle is taken while full is low; the input queue feeds the
// back end, which retires one item every cycle. The result of an end-of-line item
// is written into the result queue when the item is taken and waits there until
// popped; the back end holds an end-of-line item only while that queue is full,
// and byte items keep flowing until the input queue fills. Lines longer than
// MAX_LINE_BYTES report too_long and invalid. Offsets and lengths are 10 bits.

module gopher_menu_line_parser import gmlp_pkg::*; #(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     command,
  input  logic [BYTE_W-1:0]        data_byte,
  output logic                     empty,
  input  logic                     pop,
  output logic [BYTE_W-1:0]        type_code,
  output logic                     line_valid,
  output logic signed [PORT_W-1:0] port_number,
  output logic [OFFSET_W-1:0]      display_start,
  output logic [OFFSET_W-1:0]      display_length,
  output logic [OFFSET_W-1:0]      selector_start,
  output logic [OFFSET_W-1:0]      selector_length,
  output logic [OFFSET_W-1:0]      host_start,
  output logic [OFFSET_W-1:0]      host_length,
  output logic                     too_long
);

  front_out_t fq;
  logic       take;
  result_t    res;

  gmlp_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .command   (command),
    .data_byte (data_byte),
    .full      (full),
    .fq        (fq),
    .take      (take)
  );

  gmlp_back #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .fq    (fq),
    .take  (take),
    .pop   (pop),
    .res   (res),
    .empty (empty)
  );

  assign type_code       = res.type_code;
  assign line_valid      = res.line_valid;
  assign port_number     = res.port_number;
  assign display_start   = res.display_start;
  assign display_length  = res.display_length;
  assign selector_start  = res.selector_start;
  assign selector_length = res.selector_length;
  assign host_start      = res.host_start;
  assign host_length     = res.host_length;
  assign too_long        = res.too_long;

endmodule

@@ rtl/gmlp_fifo.sv @@
// gmlp_fifo: small flip-flop queue with first-word fall-through read
// no dependencies; used between front and back and on the result side

module gmlp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ rtl/gmlp_front.sv @@
// gmlp_front: accepts items, classifies each byte and queues it for the back end
// depends on gmlp_pkg and gmlp_fifo

module gmlp_front import gmlp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              command,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              full,
  output front_out_t        fq,
  input  logic              take
);

  cmd_item_t item;
  logic      q_empty;

  always_comb begin
    item           = '0;
    item.command   = command;
    item.data_byte = data_byte;
    item.is_tab    = (data_byte == CH_TAB);
    item.is_trim   = data_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    item.is_cspace = (data_byte == CH_SPACE) || (data_byte inside {[CH_TAB:CH_CR]});
    item.is_digit  = data_byte inside {[CH_ZERO:CH_NINE]};
    item.is_sign   = data_byte inside {CH_PLUS, CH_MINUS};
    item.is_minus  = (data_byte == CH_MINUS);
    item.digit     = DIGIT_W'(data_byte - CH_ZERO);
  end

  gmlp_fifo #(
    .WIDTH($bits(cmd_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (item),
    .full    (full),
    .pop     (take),
    .rd_data (fq.item),
    .empty   (q_empty)
  );

  assign fq.valid = !q_empty;

endmodule

@@ rtl/gmlp_back.sv @@
// gmlp_back: tracks fields and port of the current line, builds the result at end of line
// depends on gmlp_pkg and gmlp_fifo

module gmlp_back import gmlp_pkg::*; #(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  front_out_t fq,
  output logic       take,
  input  logic       pop,
  output result_t    res,
  output logic       empty
);

  localparam int PW = $clog2(MAX_LINE_BYTES + 1);

  cmd_item_t item;
  logic      res_full;
  logic      do_byte;
  logic      do_eol;
  result_t   res_next;

  logic [PW-1:0]       byte_position;
  logic [BYTE_W-1:0]   type_register;
  logic [FIELD_W-1:0]  field_index;
  logic                last_was_tab;
  logic [OFFSET_W-1:0] field_begin;
  logic [OFFSET_W-1:0] first_content;
  logic [OFFSET_W-1:0] last_content;
  logic                content_seen;
  logic [OFFSET_W-1:0] bound_start  [TEXT_FIELDS];
  logic [OFFSET_W-1:0] bound_length [TEXT_FIELDS];
  logic [PORT_W-1:0]   port_magnitude;
  logic                port_negative;
  port_phase_t         port_phase;
  logic                port_digit_seen;
  logic                port_overflow;
  logic                length_exceeded;

  logic [PORT_W-1:0]   port_magnitude_next;
  logic                port_negative_next;
  port_phase_t         port_phase_next;
  logic                port_digit_seen_next;
  logic                port_overflow_next;
  logic                accumulate;
  logic [ACC_W-1:0]    acc;

  logic [OFFSET_W-1:0] pos10;
  logic [OFFSET_W-1:0] close_start;
  logic [OFFSET_W-1:0] close_length;
  logic [FIELD_W-1:0]  field_inc;
  logic                close_eol;
  logic [FIELD_W-1:0]  field_eff;
  logic [OFFSET_W-1:0] eff_start  [TEXT_FIELDS];
  logic [OFFSET_W-1:0] eff_length [TEXT_FIELDS];
  logic                line_ok;
  logic                info_ok;

  assign item    = fq.item;
  assign take    = fq.valid && (item.command == CMD_BYTE || !res_full);
  assign do_byte = take && (item.command == CMD_BYTE);
  assign do_eol  = take && (item.command == CMD_EOL);

  assign pos10        = OFFSET_W'(byte_position);
  assign close_start  = content_seen ? first_content : field_begin;
  assign close_length = content_seen ? (last_content - first_content + 1'b1)
                                     : (pos10 - field_begin);
  assign field_inc    = (field_index < FIELD_SAT) ? field_index + 1'b1 : field_index;

  // port phase and accumulator
  always_comb begin
    port_phase_next = port_phase;
    accumulate      = 1'b0;
    case (port_phase)
      PH_SKIP: begin
        if (item.is_cspace) begin
          port_phase_next = PH_SKIP;
        end else if (item.is_sign) begin
          port_phase_next = PH_DIGITS;
        end else if (!item.is_digit) begin
          port_phase_next = PH_DONE;
        end else begin
          port_phase_next = PH_DIGITS;
          accumulate      = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (!item.is_digit) begin
          port_phase_next = PH_DONE;
        end else begin
          accumulate = 1'b1;
        end
      end
      default: port_phase_next = port_phase;
    endcase
  end

  assign acc = {{(ACC_W - PORT_W){1'b0}}, port_magnitude} * ACC_W'(10)
             + ACC_W'(item.digit);

  always_comb begin
    port_negative_next   = port_negative;
    port_digit_seen_next = port_digit_seen;
    port_overflow_next   = port_overflow;
    port_magnitude_next  = port_magnitude;
    if (port_phase == PH_SKIP && !item.is_cspace && item.is_sign) begin
      port_negative_next = item.is_minus;
    end
    if (accumulate) begin
      port_digit_seen_next = 1'b1;
      if (!port_overflow) begin
        if (acc > ACC_W'(PORT_NEG_LIMIT)) begin
          port_overflow_next = 1'b1;
        end else begin
          port_magnitude_next = PORT_W'(acc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_eol) begin
      byte_position   <= '0;
      type_register   <= '0;
      field_index     <= '0;
      last_was_tab    <= 1'b0;
      field_begin     <= '0;
      first_content   <= '0;
      last_content    <= '0;
      content_seen    <= 1'b0;
      for (int k = 0; k < TEXT_FIELDS; k++) begin
        bound_start[k]  <= '0;
        bound_length[k] <= '0;
      end
      port_magnitude  <= '0;
      port_negative   <= 1'b0;
      port_phase      <= PH_SKIP;
      port_digit_seen <= 1'b0;
      port_overflow   <= 1'b0;
      length_exceeded <= 1'b0;
    end else if (do_byte) begin
      if (length_exceeded || byte_position >= PW'(MAX_LINE_BYTES)) begin
        length_exceeded <= 1'b1;
      end else begin
        byte_position <= byte_position + 1'b1;
        if (byte_position == '0) begin
          type_register <= item.data_byte;
          field_begin   <= OFFSET_W'(1);
        end else if (item.is_tab) begin
          if (field_index < FIELD_W'(TEXT_FIELDS)) begin
            bound_start[field_index[1:0]]  <= close_start;
            bound_length[field_index[1:0]] <= close_length;
          end
          field_index  <= field_inc;
          field_begin  <= pos10 + 1'b1;
          content_seen <= 1'b0;
          last_was_tab <= 1'b1;
        end else begin
          last_was_tab <= 1'b0;
          if (field_index < FIELD_W'(TEXT_FIELDS)) begin
            if (!item.is_trim) begin
              if (!content_seen) begin
                first_content <= pos10;
              end
              last_content <= pos10;
              content_seen <= 1'b1;
            end
          end else if (field_index == FIELD_PORT) begin
            port_phase      <= port_phase_next;
            port_negative   <= port_negative_next;
            port_digit_seen <= port_digit_seen_next;
            port_overflow   <= port_overflow_next;
            port_magnitude  <= port_magnitude_next;
          end
        end
      end
    end
  end

  // end of line: close the open part and build the result
  always_comb begin
    close_eol = !length_exceeded && (byte_position >= PW'(2)) && !last_was_tab;
    field_eff = close_eol ? field_inc : field_index;
    for (int k = 0; k < TEXT_FIELDS; k++) begin
      if (close_eol && field_index == FIELD_W'(k)) begin
        eff_start[k]  = close_start;
        eff_length[k] = close_length;
      end else begin
        eff_start[k]  = bound_start[k];
        eff_length[k] = bound_length[k];
      end
    end
    line_ok = !length_exceeded && (field_eff >= FIELD_SAT) && port_digit_seen
              && !port_overflow && (port_negative || port_magnitude != PORT_NEG_LIMIT);
    info_ok = !length_exceeded && (byte_position != '0) && (field_eff < FIELD_SAT)
              && (field_eff != '0) && (type_register == TYPE_INFO);

    res_next           = '0;
    res_next.type_code = type_register;
    res_next.too_long  = length_exceeded;
    if (line_ok) begin
      res_next.line_valid      = 1'b1;
      res_next.port_number     = port_negative ? PORT_W'(32'd0 - port_magnitude)
                                               : port_magnitude;
      res_next.display_start   = eff_start[0];
      res_next.display_length  = eff_length[0];
      res_next.selector_start  = eff_start[1];
      res_next.selector_length = eff_length[1];
      res_next.host_start      = eff_start[2];
      res_next.host_length     = eff_length[2];
    end else if (info_ok) begin
      res_next.line_valid     = 1'b1;
      res_next.display_start  = eff_start[0];
      res_next.display_length = eff_length[0];
    end
  end

  gmlp_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (do_eol),
    .wr_data (res_next),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res),
    .empty   (empty)
  );

endmodule

@@ rtl/gmlp_checker.sv @@
// gmlp_checker: port-level checks on the gopher menu line parser, bound to the top level
// depends on gmlp_pkg and gopher_menu_line_parser

module gmlp_checker import gmlp_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     full,
  input logic                     empty,
  input logic                     pop,
  input logic [BYTE_W-1:0]        type_code,
  input logic                     line_valid,
  input logic signed [PORT_W-1:0] port_number,
  input logic [OFFSET_W-1:0]      display_length,
  input logic [OFFSET_W-1:0]      selector_length,
  input logic [OFFSET_W-1:0]      host_length,
  input logic                     too_long
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !line_valid |-> port_number == '0 && display_length == '0
      && selector_length == '0 && host_length == '0)
    else $error("invalid line carries field data");

  a_long_invalid: assert property (@(posedge clk) disable iff (rst)
    !empty && too_long |-> !line_valid)
    else $error("too long line reported valid");

  a_result_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown({type_code, line_valid, port_number, too_long}))
    else $error("waiting result has unknown bits");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(type_code) && $stable(line_valid))
    else $error("waiting result changed");

endmodule

bind gopher_menu_line_parser gmlp_checker u_gmlp_checker (
  .clk             (clk),
  .rst             (rst),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .type_code       (type_code),
  .line_valid      (line_valid),
  .port_number     (port_number),
  .display_length  (display_length),
  .selector_length (selector_length),
  .host_length     (host_length),
  .too_long        (too_long)
);
